// ----- sv/graph_bfs_dfs_traversal_top_macros.svh -----
// Assertion macros for the graph search block.
// Included by graph_bfs_dfs_traversal_top; no other dependencies.
`ifndef GRAPH_BFS_DFS_TRAVERSAL_TOP_MACROS_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_TOP_MACROS_SVH
`ifndef SYNTHESIS
// checked property, switched off while reset is asserted
`define GBDT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked property, also watched through reset
`define GBDT_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GBDT_ASSERT(lbl, clk, rst_n, prop, msg)
`define GBDT_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/gbdt_pkg.sv -----
// Shared types, constants and helpers of the graph search block.
// No dependencies; imported by every module of the block.
package gbdt_pkg;

    localparam int GBDT_MAX_VERTICES = 32;
    localparam int ROW_W   = 32;          // adjacency row width
    localparam int VTX_W   = 5;           // vertex index width
    localparam int CNT_W   = 6;           // counts and pointers
    localparam int MODE_W  = 2;
    localparam int VMEM_DEPTH = 32;       // queue / stack entries

    localparam logic [CNT_W-1:0] VC_RESET = 6'd32;

    // item modes
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BFS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DFS  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_QWAIT,
        ST_FLUSH,
        ST_ERR
    } gbdt_state_t;

    // row store access
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [VTX_W-1:0] addr;
        logic [ROW_W-1:0] wdata;
    } row_req_t;

    // queue / stack memory access
    typedef struct packed {
        logic             wr_en;
        logic [VTX_W-1:0] wr_addr;
        logic [VTX_W-1:0] wr_data;
        logic             rd_en;
        logic [VTX_W-1:0] rd_addr;
    } vmem_req_t;

    // walker status
    typedef struct packed {
        logic idle;
        logic pend_valid;
    } walk_stat_t;

    // index of the lowest set bit (0 when none)
    function automatic logic [VTX_W-1:0] gbdt_lowest(input logic [ROW_W-1:0] bits);
        logic [VTX_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = VTX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- sv/gbdt_row_store.sv -----
// Adjacency row store: one 32-bit neighbour bitmap per vertex.
// Depends on gbdt_pkg. Per-entry valid bits give the all-zero reset.
module gbdt_row_store
    import gbdt_pkg::*;
#(
    parameter int MAX_VERTICES = GBDT_MAX_VERTICES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  row_req_t         req,
    output logic [ROW_W-1:0] rdata
);

    localparam int ROW_DEPTH = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
    localparam int AW        = $clog2(ROW_DEPTH);

    logic [ROW_W-1:0]     mem [ROW_DEPTH];
    logic [ROW_DEPTH-1:0] valid_reg;
    logic [ROW_W-1:0]     rd_data_reg;
    logic                 rd_valid_reg;
    logic [AW-1:0]        addr;

    assign addr = req.addr[AW-1:0];

    // storage array, registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    // valid bits: cleared at once by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    // never-written rows read as zero
    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- sv/gbdt_vtx_mem.sv -----
// Vertex memory shared by the BFS queue and the DFS stack.
// Depends on gbdt_pkg. Contents undefined until written by a walk.
module gbdt_vtx_mem
    import gbdt_pkg::*;
(
    input  logic             aclk,
    input  vmem_req_t        req,
    output logic [VTX_W-1:0] rdata
);

    logic [VTX_W-1:0] mem [VMEM_DEPTH];
    logic [VTX_W-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// ----- sv/gbdt_walker.sv -----
// Walk controller: sequencer, visited mask, queue/stack pointers, result register.
// Depends on gbdt_pkg; drives gbdt_row_store and gbdt_vtx_mem.
module gbdt_walker
    import gbdt_pkg::*;
#(
    parameter int MAX_VERTICES = GBDT_MAX_VERTICES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CNT_W-1:0]  vertex_count,
    input  logic              s_valid,
    input  logic [MODE_W-1:0] s_mode,
    input  logic [VTX_W-1:0]  s_vertex,
    input  logic [ROW_W-1:0]  s_row_bits,
    output walk_stat_t        stat,
    output row_req_t          row_req,
    input  logic [ROW_W-1:0]  row_rdata,
    output vmem_req_t         vmem_req,
    input  logic [VTX_W-1:0]  vmem_rdata,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [VTX_W-1:0]  m_visited_vertex,
    output logic              m_last,
    output logic              m_error
);

    localparam int ROW_CAP = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;

    gbdt_state_t      state_reg, state_next;
    logic             dfs_reg, dfs_next;
    logic [ROW_W-1:0] visited_reg, visited_next;
    logic [CNT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] sp_reg, sp_next;
    logic [VTX_W-1:0] pend_vertex_reg, pend_vertex_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [VTX_W-1:0] out_vertex_reg, out_vertex_next;
    logic             out_last_reg, out_last_next;
    logic             out_error_reg, out_error_next;

    logic [CNT_W-1:0] live_n;
    logic [ROW_W-1:0] live_mask;
    logic [ROW_W-1:0] cand;
    logic             cand_any;
    logic [VTX_W-1:0] cand_idx;
    logic             accept;
    logic             is_walk;
    logic             start_ok;
    logic             load_ok;
    logic             out_free;
    logic             walk_end;
    logic [CNT_W-1:0] sp_below;

    // effective vertex count and row mask
    assign live_n = (vertex_count > CNT_W'(ROW_CAP)) ? CNT_W'(ROW_CAP) : vertex_count;

    always_comb begin
        for (int i = 0; i < ROW_W; i++) begin
            live_mask[i] = (CNT_W'(i) < live_n);
        end
    end

    // unvisited neighbours of the row in hand
    assign cand     = row_rdata & live_mask & ~visited_reg;
    assign cand_any = |cand;
    assign cand_idx = gbdt_lowest(cand);

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign is_walk  = (s_mode == MODE_BFS) || (s_mode == MODE_DFS);
    assign start_ok = {1'b0, s_vertex} < live_n;
    assign load_ok  = {2'b00, s_vertex} < 7'(MAX_VERTICES);
    assign out_free = !out_valid_reg || m_ready;
    assign walk_end = dfs_reg ? (sp_reg == CNT_W'(1)) : (head_reg == tail_reg);
    assign sp_below = sp_reg - CNT_W'(2);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && is_walk) begin
                    state_next = start_ok ? ST_SCAN : ST_ERR;
                end
            end
            ST_SCAN: begin
                if (!cand_any) begin
                    state_next = walk_end ? ST_FLUSH : ST_QWAIT;
                end
            end
            ST_QWAIT: begin
                state_next = ST_SCAN;
            end
            ST_FLUSH, ST_ERR: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath, memory requests and result beats
    always_comb begin
        dfs_next         = dfs_reg;
        visited_next     = visited_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        sp_next          = sp_reg;
        pend_vertex_next = pend_vertex_reg;
        pend_valid_next  = pend_valid_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_vertex_next  = out_vertex_reg;
        out_last_next    = out_last_reg;
        out_error_next   = out_error_reg;
        row_req          = '0;
        vmem_req         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_mode == MODE_LOAD)) begin
                    row_req.wr_en = load_ok;
                    row_req.addr  = s_vertex;
                    row_req.wdata = s_row_bits;
                end else if (accept && is_walk && start_ok) begin
                    // start vertex is emitted first, its row fetched now
                    row_req.rd_en    = 1'b1;
                    row_req.addr     = s_vertex;
                    visited_next     = ROW_W'(1) << s_vertex;
                    pend_vertex_next = s_vertex;
                    pend_valid_next  = 1'b1;
                    dfs_next         = (s_mode == MODE_DFS);
                    head_next        = '0;
                    tail_next        = '0;
                    sp_next          = CNT_W'(1);
                    vmem_req.wr_en   = 1'b1;
                    vmem_req.wr_addr = '0;
                    vmem_req.wr_data = s_vertex;
                end
            end
            ST_SCAN: begin
                if (cand_any) begin
                    if (out_free) begin
                        // previous vertex leaves, new one is held back
                        out_valid_next   = 1'b1;
                        out_vertex_next  = pend_vertex_reg;
                        out_last_next    = 1'b0;
                        out_error_next   = 1'b0;
                        pend_vertex_next = cand_idx;
                        visited_next     = visited_reg | (ROW_W'(1) << cand_idx);
                        vmem_req.wr_en   = 1'b1;
                        vmem_req.wr_data = cand_idx;
                        if (dfs_reg) begin
                            // push and descend at once
                            vmem_req.wr_addr = sp_reg[VTX_W-1:0];
                            sp_next          = sp_reg + CNT_W'(1);
                            row_req.rd_en    = 1'b1;
                            row_req.addr     = cand_idx;
                        end else begin
                            vmem_req.wr_addr = tail_reg[VTX_W-1:0];
                            tail_next        = tail_reg + CNT_W'(1);
                        end
                    end
                end else if (dfs_reg) begin
                    // pop; fetch the frame beneath unless the stack empties
                    sp_next = sp_reg - CNT_W'(1);
                    if (!walk_end) begin
                        vmem_req.rd_en   = 1'b1;
                        vmem_req.rd_addr = sp_below[VTX_W-1:0];
                    end
                end else if (!walk_end) begin
                    // dequeue next vertex
                    vmem_req.rd_en   = 1'b1;
                    vmem_req.rd_addr = head_reg[VTX_W-1:0];
                    head_next        = head_reg + CNT_W'(1);
                end
            end
            ST_QWAIT: begin
                row_req.rd_en = 1'b1;
                row_req.addr  = vmem_rdata;
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = pend_vertex_reg;
                    out_last_next   = 1'b1;
                    out_error_next  = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = '0;
                    out_last_next   = 1'b1;
                    out_error_next  = 1'b1;
                end
            end
            default: begin
                out_valid_next = out_valid_reg && !m_ready;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            dfs_reg        <= 1'b0;
            visited_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            sp_reg         <= '0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            dfs_reg        <= dfs_next;
            visited_reg    <= visited_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            sp_reg         <= sp_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_vertex_reg <= pend_vertex_next;
        out_vertex_reg  <= out_vertex_next;
        out_last_reg    <= out_last_next;
        out_error_reg   <= out_error_next;
    end

    assign stat.idle       = (state_reg == ST_IDLE);
    assign stat.pend_valid = pend_valid_reg;

    assign m_valid          = out_valid_reg;
    assign m_visited_vertex = out_vertex_reg;
    assign m_last           = out_last_reg;
    assign m_error          = out_error_reg;

endmodule

// ----- sv/graph_bfs_dfs_traversal_top.sv -----
// Channel    | handshake            | beat contents
// -----------+----------------------+----------------------------------------
// input      | s_valid / s_ready    | s_mode, s_vertex, s_row_bits
// result     | m_valid / m_ready    | m_visited_vertex, m_last, m_error
// config     | cfg_valid / cfg_ready| cfg_data (vertex count)
//
// A load or an ignored item leaves the walker idle; a bad start vertex passes through
// the error state, which sends the error beat. A walk covers at most 32 vertices. Each
// stack pop or dequeue that does not end the walk reads the vertex memory, then the row
// store. Reset clears the row store valid bits at once, no clearing pass.
// While m_ready is low with a beat waiting, the walk holds at its next emission.
// Top level of the graph search block. Depends on gbdt_pkg, gbdt_row_store,
// gbdt_vtx_mem, gbdt_walker and graph_bfs_dfs_traversal_top_macros.svh.
`include "graph_bfs_dfs_traversal_top_macros.svh"

module graph_bfs_dfs_traversal_top
    import gbdt_pkg::*;
#(
    parameter int MAX_VERTICES = GBDT_MAX_VERTICES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [MODE_W-1:0] s_mode,
    input  logic [VTX_W-1:0]  s_vertex,
    input  logic [ROW_W-1:0]  s_row_bits,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [VTX_W-1:0]  m_visited_vertex,
    output logic              m_last,
    output logic              m_error
);

    logic [CNT_W-1:0] vertex_count_reg;
    walk_stat_t       walk_stat;
    row_req_t         row_req;
    logic [ROW_W-1:0] row_rdata;
    vmem_req_t        vmem_req;
    logic [VTX_W-1:0] vmem_rdata;

    // vertex count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= VC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            vertex_count_reg <= cfg_data;
        end
    end

    assign s_ready = walk_stat.idle;

    gbdt_row_store #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_row_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (row_req),
        .rdata   (row_rdata)
    );

    gbdt_vtx_mem u_vtx_mem (
        .aclk  (aclk),
        .req   (vmem_req),
        .rdata (vmem_rdata)
    );

    gbdt_walker #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_walker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .vertex_count     (vertex_count_reg),
        .s_valid          (s_valid),
        .s_mode           (s_mode),
        .s_vertex         (s_vertex),
        .s_row_bits       (s_row_bits),
        .stat             (walk_stat),
        .row_req          (row_req),
        .row_rdata        (row_rdata),
        .vmem_req         (vmem_req),
        .vmem_rdata       (vmem_rdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_visited_vertex (m_visited_vertex),
        .m_last           (m_last),
        .m_error          (m_error)
    );

    // checks
    `GBDT_ASSERT_RST(a_reset_no_beat, aclk, !aresetn |=> !m_valid, "result beat after reset")
    `GBDT_ASSERT(a_err_is_last, aclk, aresetn, m_valid && m_error |-> m_last, "error beat not last")
    `GBDT_ASSERT(a_idle_no_pend, aclk, aresetn, walk_stat.idle |-> !walk_stat.pend_valid, "idle with vertex held")
    `GBDT_ASSERT(a_load_one_cycle, aclk, aresetn, s_valid && s_ready && s_mode == MODE_LOAD |=> s_ready, "load left block busy")

endmodule

// ----- test/tb.sv -----
// Testbench for graph_bfs_dfs_traversal_top: a directed table, then random phases
// at several vertex counts, each result checked against an in-bench graph walker or a typed expectation.
// Depends on gbdt_pkg and graph_bfs_dfs_traversal_top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbdt_pkg::*;

    localparam int GAP_MAX      = 18;
    localparam int DRAIN_CYCLES = 10;
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_BEATS  = 34;
    localparam int CYCLE_LIMIT  = 1500000;

    // one result beat: visited vertex, end of walk, bad start
    typedef struct packed {
        logic [VTX_W-1:0] vtx;
        logic             is_last;
        logic             is_err;
    } visit_t;

    typedef enum logic {STEP_BEAT, STEP_COUNT} step_kind_t;
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} exp_kind_t;

    // one row of the directed table
    typedef struct packed {
        step_kind_t        kind;
        logic [MODE_W-1:0] mode;
        logic [VTX_W-1:0]  vtx;
        logic [ROW_W-1:0]  bits;
        exp_kind_t         how;
        logic [VTX_W-1:0]  typed_vtx;
        logic              typed_err;
    } plan_row_t;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [MODE_W-1:0] s_mode = MODE_LOAD;
    logic [VTX_W-1:0]  s_vertex = '0;
    logic [ROW_W-1:0]  s_row_bits = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [VTX_W-1:0]  m_visited_vertex;
    logic              m_last;
    logic              m_error;

    // walker copy of the block state
    logic [ROW_W-1:0] graph_rows [GBDT_MAX_VERTICES];
    logic [CNT_W-1:0] vcount;
    visit_t           walk_out [32];
    visit_t           pending_visits [$];
    visit_t           want;
    plan_row_t        plan [$];

    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;
    int sink_hold = 0;
    int cycles = 0;
    int fails = 0;
    int beats_in = 0;
    int ignored_in = 0;
    int walks_in = 0;
    int results_seen = 0;
    int count_writes = 0;

    graph_bfs_dfs_traversal_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_vertex         (s_vertex),
        .s_row_bits       (s_row_bits),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_visited_vertex (m_visited_vertex),
        .m_last           (m_last),
        .m_error          (m_error)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // vertices in use: the register, clipped to the row width
    function automatic int live_count();
        return (int'(vcount) > ROW_W) ? ROW_W : int'(vcount);
    endfunction

    // works out the results of one input beat into walk_out; loads update the rows
    function automatic int predict_item(input logic [MODE_W-1:0] mode,
                                        input logic [VTX_W-1:0] vtx,
                                        input logic [ROW_W-1:0] bits);
        int n, cnt, head, depth, cur, j, k;
        logic [ROW_W-1:0] mask, seen, nb;
        int order [32];
        int stk_node [32];
        int stk_res [32];
        if (mode == MODE_LOAD) begin
            graph_rows[vtx] = bits;
            return 0;
        end
        if (mode == MODE_NONE) begin
            return 0;
        end
        n = live_count();
        if (int'(vtx) >= n) begin
            walk_out[0] = visit_t'({{VTX_W{1'b0}}, 1'b1, 1'b1});
            return 1;
        end
        mask = (n >= ROW_W) ? {ROW_W{1'b1}} : ((32'd1 << n) - 32'd1);
        seen = 32'd1 << vtx;
        order[0] = int'(vtx);
        cnt = 1;
        if (mode == MODE_BFS) begin
            // visit order doubles as the queue
            head = 0;
            while (head < cnt) begin
                cur = order[head];
                head++;
                nb = graph_rows[cur] & mask;
                for (j = 0; j < n; j++) begin
                    if (nb[j] && !seen[j]) begin
                        seen[j] = 1'b1;
                        order[cnt] = j;
                        cnt++;
                    end
                end
            end
        end else begin
            // preorder with a stack of vertex and resume position
            stk_node[0] = int'(vtx);
            stk_res[0] = 0;
            depth = 1;
            while (depth > 0) begin
                cur = stk_node[depth-1];
                j = stk_res[depth-1];
                nb = graph_rows[cur] & mask;
                while (j < n && !(nb[j] && !seen[j])) begin
                    j++;
                end
                if (j >= n) begin
                    depth--;
                end else begin
                    stk_res[depth-1] = j + 1;
                    seen[j] = 1'b1;
                    order[cnt] = j;
                    cnt++;
                    stk_node[depth] = j;
                    stk_res[depth] = 0;
                    depth++;
                end
            end
        end
        for (k = 0; k < cnt; k++) begin
            walk_out[k] = visit_t'({VTX_W'(order[k]), k == cnt - 1, 1'b0});
        end
        return cnt;
    endfunction

    function automatic plan_row_t beat_row(input logic [MODE_W-1:0] mode,
                                           input logic [VTX_W-1:0] vtx,
                                           input logic [ROW_W-1:0] bits,
                                           input exp_kind_t how,
                                           input logic [VTX_W-1:0] tv = '0,
                                           input logic te = 1'b0);
        plan_row_t r;
        r.kind = STEP_BEAT;
        r.mode = mode;
        r.vtx = vtx;
        r.bits = bits;
        r.how = how;
        r.typed_vtx = tv;
        r.typed_err = te;
        return r;
    endfunction

    function automatic plan_row_t count_row(input logic [CNT_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.kind = STEP_COUNT;
        r.bits = ROW_W'(val);
        r.how = EXP_NONE;
        return r;
    endfunction

    // hold off until the block has gone quiet
    task automatic wait_drained();
        while (pending_visits.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] val);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data = val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        vcount = val;
        count_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // drive one input beat; expectations are queued once it is accepted
    task automatic send_beat(input logic [MODE_W-1:0] mode,
                             input logic [VTX_W-1:0] vtx,
                             input logic [ROW_W-1:0] bits,
                             input exp_kind_t how,
                             input logic [VTX_W-1:0] tv,
                             input logic te);
        int gap, nres, k;
        gap = src_calm ? 0 : $urandom_range(0, GAP_MAX);
        repeat (gap) @(negedge aclk);
        s_valid = 1'b1;
        s_mode = mode;
        s_vertex = vtx;
        s_row_bits = bits;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        nres = predict_item(mode, vtx, bits);
        if (how == EXP_MODEL) begin
            for (k = 0; k < nres; k++) begin
                pending_visits.push_back(walk_out[k]);
            end
        end else if (how == EXP_ONE) begin
            pending_visits.push_back(visit_t'({tv, 1'b1, te}));
        end
        beats_in++;
        if (mode == MODE_NONE) ignored_in++;
        if (mode == MODE_BFS || mode == MODE_DFS) walks_in++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // random beat: mostly loads and walks inside the live vertices
    task automatic random_beat();
        logic [MODE_W-1:0] mode;
        logic [VTX_W-1:0]  vtx;
        logic [ROW_W-1:0]  bits;
        int n, pick;
        n = live_count();
        pick = $urandom_range(0, 99);
        if (pick < 45) mode = MODE_LOAD;
        else if (pick < 70) mode = MODE_BFS;
        else if (pick < 95) mode = MODE_DFS;
        else mode = MODE_NONE;
        if (n > 0 && $urandom_range(0, 9) < 8) vtx = VTX_W'($urandom_range(0, n - 1));
        else vtx = VTX_W'($urandom);
        bits = '0;
        case ($urandom_range(0, 6))
            0: bits = $urandom;
            1, 2, 3: begin
                // sparse rows give long, thin walks
                repeat ($urandom_range(1, 3)) begin
                    bits[$urandom_range(0, (n > 0) ? n - 1 : 0)] = 1'b1;
                end
            end
            4: bits = $urandom & $urandom & $urandom;
            5: bits = '0;
            default: bits = '1;
        endcase
        send_beat(mode, vtx, bits, EXP_MODEL, '0, 1'b0);
    endtask

    // result side: after each beat, ready stays low while the drawn sink_hold counts down
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_ready = 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            m_ready = aresetn;
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_visits.size() == 0) begin
                fails++;
                $display("%0t: result expected none, got vertex %0d last %0b error %0b",
                         $time, m_visited_vertex, m_last, m_error);
            end else begin
                want = pending_visits.pop_front();
                if (m_visited_vertex !== want.vtx) begin
                    fails++;
                    $display("%0t: visited_vertex expected %0d, got %0d",
                             $time, want.vtx, m_visited_vertex);
                end
                if (m_last !== want.is_last) begin
                    fails++;
                    $display("%0t: last expected %0b, got %0b", $time, want.is_last, m_last);
                end
                if (m_error !== want.is_err) begin
                    fails++;
                    $display("%0t: error expected %0b, got %0b", $time, want.is_err, m_error);
                end
            end
            results_seen++;
            sink_hold = sink_calm ? 0 : $urandom_range(0, GAP_MAX);
        end
    end

    // stimulus
    initial begin
        int phase_counts [10];
        int target;
        vcount = VC_RESET;
        for (int i = 0; i < GBDT_MAX_VERTICES; i++) begin
            graph_rows[i] = '0;
        end

        // directed table: empty graph, one full row, small graph with loops,
        // bad starts, count of zero and one, loads above the count, ignored mode
        plan.push_back(beat_row(MODE_DFS, 5'd31, '0, EXP_ONE, 5'd31, 1'b0));
        plan.push_back(beat_row(MODE_BFS, 5'd0, '0, EXP_ONE, 5'd0, 1'b0));
        plan.push_back(beat_row(MODE_NONE, 5'd7, '1, EXP_NONE));
        plan.push_back(beat_row(MODE_LOAD, 5'd0, '1, EXP_NONE));
        plan.push_back(beat_row(MODE_BFS, 5'd0, '0, EXP_MODEL));
        plan.push_back(beat_row(MODE_DFS, 5'd0, '0, EXP_MODEL));
        plan.push_back(beat_row(MODE_LOAD, 5'd0, 32'h0000_0006, EXP_NONE));
        plan.push_back(beat_row(MODE_LOAD, 5'd1, 32'h8000_0003, EXP_NONE));
        plan.push_back(beat_row(MODE_LOAD, 5'd2, 32'h0000_0010, EXP_NONE));
        plan.push_back(beat_row(MODE_LOAD, 5'd31, 32'h0000_0004, EXP_NONE));
        plan.push_back(beat_row(MODE_BFS, 5'd0, '0, EXP_MODEL));
        plan.push_back(beat_row(MODE_DFS, 5'd0, '0, EXP_MODEL));
        plan.push_back(beat_row(MODE_DFS, 5'd31, '0, EXP_MODEL));
        plan.push_back(count_row(6'd0));
        plan.push_back(beat_row(MODE_BFS, 5'd0, '0, EXP_ONE, 5'd0, 1'b1));
        plan.push_back(beat_row(MODE_DFS, 5'd31, '0, EXP_ONE, 5'd0, 1'b1));
        plan.push_back(count_row(6'd1));
        plan.push_back(beat_row(MODE_BFS, 5'd0, '0, EXP_MODEL));
        plan.push_back(beat_row(MODE_DFS, 5'd1, '0, EXP_ONE, 5'd0, 1'b1));
        plan.push_back(beat_row(MODE_LOAD, 5'd20, 32'h0000_FFFF, EXP_NONE));
        plan.push_back(count_row(6'd63));
        plan.push_back(beat_row(MODE_DFS, 5'd20, '0, EXP_MODEL));
        plan.push_back(beat_row(MODE_BFS, 5'd1, '0, EXP_MODEL));
        plan.push_back(beat_row(MODE_NONE, 5'd0, '0, EXP_NONE));
        plan.push_back(count_row(6'd32));

        phase_counts = '{1, 63, 0, 5, 12, 2, 31, 20, 7, 32};
        phase_counts[8] = $urandom_range(0, 63);

        // reset, released on a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_COUNT) begin
                write_count(CNT_W'(plan[i].bits));
            end else begin
                send_beat(plan[i].mode, plan[i].vtx, plan[i].bits, plan[i].how,
                          plan[i].typed_vtx, plan[i].typed_err);
            end
        end

        // random phases, one vertex count each
        for (int p = 0; p < 10; p++) begin
            write_count(CNT_W'(phase_counts[p]));
            src_calm = (p == 4) || ($urandom_range(0, 3) == 0);
            sink_calm = (p == 4) || ($urandom_range(0, 3) == 0);
            target = beats_in - ignored_in + PHASE_BEATS;
            while (beats_in - ignored_in < target) begin
                // now and then the sender waits for every result to come back
                if ($urandom_range(0, 29) == 0) wait_drained();
                random_beat();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("summary: %0d input beats, %0d of them walks, %0d results compared",
                 beats_in, walks_in, results_seen);
        $display("summary: %0d vertex count writes, %0d mismatches", count_writes, fails);
        if (fails == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- graph_bfs_dfs_traversal_top.f -----
+incdir+sv
sv/gbdt_pkg.sv
sv/gbdt_row_store.sv
sv/gbdt_vtx_mem.sv
sv/gbdt_walker.sv
sv/graph_bfs_dfs_traversal_top.sv
test/tb.sv
